// File: rtl/ubf_pkg.sv
// shared types and constants of the uart byte fifo with character match
// no dependencies

package ubf_pkg;

    typedef enum logic [2:0] {
        FUNC_RX_BYTE = 3'd0,
        FUNC_TX_FREE = 3'd1,
        FUNC_PUT     = 3'd2,
        FUNC_GET     = 3'd3,
        FUNC_PEEK    = 3'd4,
        FUNC_FLUSH   = 3'd5
    } t_func;

    localparam logic [1:0] CFG_MATCH_A     = 2'd0;
    localparam logic [1:0] CFG_MATCH_B     = 2'd1;
    localparam logic [1:0] CFG_SLOTS_USED  = 2'd2;
    localparam logic [1:0] CFG_MATCH_EN    = 2'd3;

    localparam logic [7:0] EMPTY_BYTE = 8'hFF;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] rx_data;
        logic       rx_valid;
        logic       put_accepted;
        logic [7:0] tx_data;
        logic       tx_valid;
        logic       match_hit;
        logic       match_slot;
        logic       overrun;
        logic [7:0] rx_level;
        logic [7:0] tx_level;
        logic       tx_irq_enable;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

endpackage

// File: rtl/ubf_ram.sv
// generic single write port ram with registered read
// no dependencies

module ubf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ubf_ctrl.sv
// request sequencer: idle, execute, load result
// depends on ubf_pkg

module ubf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output ubf_pkg::t_cmd o_cmd
);

    import ubf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_ready;
        load_ok     = ~r_out_valid | i_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_LOAD;
            end
            ST_LOAD: begin
                if (load_ok) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: rtl/ubf_dp.sv
// datapath: ring pointers, fill counts, match compare, stores and result register
// depends on ubf_pkg and ubf_ram

module ubf_dp #(
    parameter int TX_DEPTH    = 128,
    parameter int RX_DEPTH    = 128,
    parameter int MATCH_SLOTS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ubf_pkg::t_cmd i_cmd,
    input  ubf_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    output ubf_pkg::t_rsp o_rsp
);

    import ubf_pkg::*;

    localparam int TAW  = $clog2(TX_DEPTH);
    localparam int RAW  = $clog2(RX_DEPTH);
    localparam int TFW  = $clog2(TX_DEPTH + 1);
    localparam int RFW  = $clog2(RX_DEPTH + 1);
    localparam int TLVW = (TFW > 8) ? TFW : 8;
    localparam int RLVW = (RFW > 8) ? RFW : 8;

    logic [7:0] r_match_a, r_match_b;
    logic [1:0] r_slots_used;
    logic       r_match_en;

    t_req r_req;
    t_rsp r_res, n_res, r_out;
    t_rsp load_val;
    logic r_sel_rx, n_sel_rx, r_sel_tx, n_sel_tx;

    logic [TAW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [TFW-1:0] r_tx_fill, n_tx_fill;
    logic [RAW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [RFW-1:0] r_rx_fill, n_rx_fill;
    logic           r_irq_on, n_irq_on;

    logic       tx_we, tx_re, rx_we, rx_re;
    logic [7:0] tx_rdata, rx_rdata;
    logic [1:0] used_sat;
    logic       hit, slot;
    logic [TLVW-1:0] tx_lvl_ext;
    logic [RLVW-1:0] rx_lvl_ext;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_a    <= '0;
            r_match_b    <= '0;
            r_slots_used <= '0;
            r_match_en   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATCH_A:    r_match_a    <= i_cfg_data;
                CFG_MATCH_B:    r_match_b    <= i_cfg_data;
                CFG_SLOTS_USED: r_slots_used <= i_cfg_data[1:0];
                CFG_MATCH_EN:   r_match_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_tx_fill <= '0;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_rx_fill <= '0;
            r_irq_on  <= 1'b0;
        end else if (i_cmd.exec) begin
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_tx_fill <= n_tx_fill;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_rx_fill <= n_rx_fill;
            r_irq_on  <= n_irq_on;
        end
    end

    // merge ram read data into the result
    always_comb begin
        load_val = r_res;
        if (r_sel_rx) begin
            load_val.rx_data = rx_rdata;
        end
        if (r_sel_tx) begin
            load_val.tx_data = tx_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_res    <= n_res;
            r_sel_rx <= n_sel_rx;
            r_sel_tx <= n_sel_tx;
        end
        if (i_cmd.load) begin
            r_out <= load_val;
        end
    end

    // match compare
    always_comb begin
        used_sat = (r_slots_used > 2'(MATCH_SLOTS)) ? 2'(MATCH_SLOTS) : r_slots_used;
        hit      = 1'b0;
        slot     = 1'b0;
        if (r_match_en) begin
            if (used_sat >= 2'd1 && r_req.data_byte == r_match_a) begin
                hit = 1'b1;
            end else if (used_sat >= 2'd2 && r_req.data_byte == r_match_b) begin
                hit  = 1'b1;
                slot = 1'b1;
            end
        end
    end

    always_comb begin
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        n_tx_fill = r_tx_fill;
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_rx_fill = r_rx_fill;
        n_irq_on  = r_irq_on;
        n_res     = '0;
        n_sel_rx  = 1'b0;
        n_sel_tx  = 1'b0;
        tx_we     = 1'b0;
        tx_re     = 1'b0;
        rx_we     = 1'b0;
        rx_re     = 1'b0;
        unique case (r_req.func)
            FUNC_RX_BYTE: begin
                n_res.match_hit  = hit;
                n_res.match_slot = slot;
                if (!hit) begin
                    if (r_rx_fill >= RFW'(RX_DEPTH)) begin
                        n_res.overrun = 1'b1;
                    end else begin
                        rx_we     = i_cmd.exec;
                        n_rx_head = (r_rx_head == RAW'(RX_DEPTH - 1)) ? '0 : r_rx_head + 1'b1;
                        n_rx_fill = r_rx_fill + 1'b1;
                    end
                end
            end
            FUNC_TX_FREE: begin
                if (r_tx_fill != '0) begin
                    tx_re          = i_cmd.exec;
                    n_sel_tx       = 1'b1;
                    n_res.tx_valid = 1'b1;
                    n_tx_tail = (r_tx_tail == TAW'(TX_DEPTH - 1)) ? '0 : r_tx_tail + 1'b1;
                    n_tx_fill = r_tx_fill - 1'b1;
                    if (r_tx_fill == TFW'(1)) begin
                        n_irq_on = 1'b0;
                    end
                end
            end
            FUNC_PUT: begin
                if (r_tx_fill < TFW'(TX_DEPTH)) begin
                    tx_we              = i_cmd.exec;
                    n_tx_head = (r_tx_head == TAW'(TX_DEPTH - 1)) ? '0 : r_tx_head + 1'b1;
                    n_tx_fill          = r_tx_fill + 1'b1;
                    n_irq_on           = 1'b1;
                    n_res.put_accepted = 1'b1;
                end
            end
            FUNC_GET: begin
                if (r_rx_fill != '0) begin
                    rx_re          = i_cmd.exec;
                    n_sel_rx       = 1'b1;
                    n_res.rx_valid = 1'b1;
                    n_rx_tail = (r_rx_tail == RAW'(RX_DEPTH - 1)) ? '0 : r_rx_tail + 1'b1;
                    n_rx_fill = r_rx_fill - 1'b1;
                end else begin
                    n_res.rx_data = EMPTY_BYTE;
                end
            end
            FUNC_PEEK: begin
                if (r_rx_fill != '0) begin
                    rx_re          = i_cmd.exec;
                    n_sel_rx       = 1'b1;
                    n_res.rx_valid = 1'b1;
                end else begin
                    n_res.rx_data = EMPTY_BYTE;
                end
            end
            FUNC_FLUSH: begin
                n_tx_head = '0;
                n_tx_tail = '0;
                n_tx_fill = '0;
                n_rx_head = '0;
                n_rx_tail = '0;
                n_rx_fill = '0;
            end
            default: ;
        endcase
        tx_lvl_ext          = TLVW'(n_tx_fill);
        rx_lvl_ext          = RLVW'(n_rx_fill);
        n_res.tx_level      = tx_lvl_ext[7:0];
        n_res.rx_level      = rx_lvl_ext[7:0];
        n_res.tx_irq_enable = n_irq_on;
    end

    ubf_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_head),
        .i_wdata (r_req.data_byte),
        .i_re    (tx_re),
        .i_raddr (r_tx_tail),
        .o_rdata (tx_rdata)
    );

    ubf_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_head),
        .i_wdata (r_req.data_byte),
        .i_re    (rx_re),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_rdata)
    );

    assign o_rsp = r_out;

endmodule

// File: rtl/uart_byte_fifo_with_char_match_unit.sv
// uart byte engine: transmit and receive ring fifos with receive character match
// result valid after execute and load; load stalls while an earlier result waits untaken
// one request at a time (capture, execute, load after the registered ram read)
// the next request is taken while a finished result still waits in the output register
// reset: synchronous active low; clears pointers, fill counts, irq enable, config registers
// depends on ubf_pkg, ubf_ctrl, ubf_dp, ubf_ram

module uart_byte_fifo_with_char_match_unit #(
    parameter int TX_DEPTH    = 128,
    parameter int RX_DEPTH    = 128,
    parameter int MATCH_SLOTS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ubf_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output ubf_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);

    import ubf_pkg::*;

    t_cmd cmd;

    ubf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    ubf_dp #(
        .TX_DEPTH    (TX_DEPTH),
        .RX_DEPTH    (RX_DEPTH),
        .MATCH_SLOTS (MATCH_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (o_rsp)
    );

endmodule
